// ===== rtl/sfg_pkg.sv =====
// Shared types, codes and defaults for the signal flow graph filter.
package sfg_pkg;

   localparam int DefNodeCount  = 8;
   localparam int DefDelayLimit = 16;

   // Command codes of a request transaction.
   localparam logic [1:0] CmdWrite  = 2'd0;
   localparam logic [1:0] CmdSample = 2'd1;
   localparam logic [1:0] CmdClear  = 2'd2;

   // Edge kinds as stored in the edge table.
   localparam logic [1:0] KindNone  = 2'd0;
   localparam logic [1:0] KindGain  = 2'd1;
   localparam logic [1:0] KindDelay = 2'd2;

   // Fraction bits of a gain; also the scale between Q16.0 samples and the Q.12 sums.
   localparam int GainFrac = 12;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         source_node;
      logic [2:0]         sink_node;
      logic [1:0]         edge_kind;
      logic signed [15:0] edge_value;
      logic signed [15:0] sample_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               write_error;
      logic               saturated;
   } rsp_type;

   // Work that the front end hands to the back end.
   typedef enum logic [1:0] {
      OpNone   = 2'd0,
      OpWrite  = 2'd1,
      OpSample = 2'd2,
      OpClear  = 2'd3
   } op_type;

   typedef struct packed {
      op_type  op;
      logic    write_error;
      req_type req;
   } job_type;

   typedef struct packed {
      logic job_ready;
      logic init_done;
   } back_status_type;

endpackage

// ===== rtl/signal_flow_graph_filter.sv =====
// Top level of the signal flow graph filter: front end, job queue and back end.
//
//   Channel  Direction  Ports                                   Payload
//   req      in         req_valid, req_ready, req_data         sfg_pkg::req_type
//   rsp      out        rsp_valid, rsp_ready, rsp_data         sfg_pkg::rsp_type
//
// In a sample transaction the back end reads every edge table entry once through the
// single read port of the edge RAM, each node sum then drains a two-stage
// multiply-accumulate pipeline, and the new history row is written one node a cycle.
// Write-edge, clear and unknown commands go from idle straight to the result state.
// After reset the edge table is cleared one entry a cycle, all 2**(2*clog2(NODE_COUNT))
// entries (64 with eight nodes), and req_ready stays low during that pass.
// A two-entry job queue lets requests be taken while the back end works, and the
// output register holds a finished result until rsp_ready takes it.
module signal_flow_graph_filter #(
   parameter int NODE_COUNT  = sfg_pkg::DefNodeCount,
   parameter int DELAY_LIMIT = sfg_pkg::DefDelayLimit
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sfg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sfg_pkg::rsp_type rsp_data
);

   // Classified jobs pass from the front end to the back end through the queue.
   logic                     job_valid;
   sfg_pkg::job_type         job_data;
   sfg_pkg::back_status_type back_status;

   sfg_front #(
      .NODE_COUNT  (NODE_COUNT),
      .DELAY_LIMIT (DELAY_LIMIT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .job_valid   (job_valid),
      .job_data    (job_data),
      .back_status (back_status)
   );

   // The back end owns the edge table, the history memory and the result register.
   sfg_back #(
      .NODE_COUNT  (NODE_COUNT),
      .DELAY_LIMIT (DELAY_LIMIT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_data    (job_data),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== rtl/sfg_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module sfg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sfg_front.sv =====
// Front end: accepts request transactions, classifies them and queues the jobs.
module sfg_front #(
   parameter int NODE_COUNT  = sfg_pkg::DefNodeCount,
   parameter int DELAY_LIMIT = sfg_pkg::DefDelayLimit
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sfg_pkg::req_type         req_data,
   output logic                     job_valid,
   output sfg_pkg::job_type         job_data,
   input  sfg_pkg::back_status_type back_status
);

   sfg_pkg::job_type job_ff [2];
   sfg_pkg::job_type job_new;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;
   logic             node_bad, delay_bad;

   // Classify the request into a job for the back end.
   always_comb begin
      node_bad  = (int'(req_data.source_node) >= NODE_COUNT) ||
                  (int'(req_data.sink_node) >= NODE_COUNT);
      delay_bad = (int'(req_data.edge_value) < 1) ||
                  (int'(req_data.edge_value) > DELAY_LIMIT);
      job_new             = '0;
      job_new.req         = req_data;
      job_new.op          = sfg_pkg::OpNone;
      job_new.write_error = 1'b0;
      case (req_data.command)
         sfg_pkg::CmdWrite: begin
            if (node_bad) begin
               job_new.op = sfg_pkg::OpNone;
            end else if (req_data.edge_kind != sfg_pkg::KindNone &&
                         req_data.edge_kind != sfg_pkg::KindGain &&
                         req_data.edge_kind != sfg_pkg::KindDelay) begin
               job_new.write_error = 1'b1;
            end else if (req_data.edge_kind == sfg_pkg::KindDelay && delay_bad) begin
               job_new.write_error = 1'b1;
            end else begin
               job_new.op = sfg_pkg::OpWrite;
            end
         end
         sfg_pkg::CmdSample: job_new.op = sfg_pkg::OpSample;
         sfg_pkg::CmdClear:  job_new.op = sfg_pkg::OpClear;
         default:            job_new.op = sfg_pkg::OpNone;
      endcase
   end

   assign req_ready = back_status.init_done && (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign job_valid = (count_ff != 2'd0);
   assign pop       = job_valid && back_status.job_ready;
   assign job_data  = job_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= job_new;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("job queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
                    (count_ff == 2'd2 && !pop) |=> !req_ready)
      else $error("queue full but request taken");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count lost a push");

endmodule

// ===== rtl/sfg_back.sv =====
// Back end: edge table, node history and the multiply-accumulate sequencer.
module sfg_back #(
   parameter int NODE_COUNT  = sfg_pkg::DefNodeCount,
   parameter int DELAY_LIMIT = sfg_pkg::DefDelayLimit
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   input  sfg_pkg::job_type         job_data,
   output sfg_pkg::back_status_type back_status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sfg_pkg::rsp_type         rsp_data
);

   localparam int NodeW     = $clog2(NODE_COUNT);
   localparam int IdxW      = (NodeW > 3) ? NodeW : 3;
   localparam int SlotW     = (DELAY_LIMIT > 1) ? $clog2(DELAY_LIMIT) : 1;
   localparam int CntW      = $clog2(DELAY_LIMIT + 1);
   localparam int EdgeAw    = 2 * NodeW;
   localparam int HistAw    = SlotW + NodeW;
   localparam int EdgeDepth = 1 << EdgeAw;
   localparam int HistDepth = 1 << HistAw;
   localparam int AccW      = 33 + NodeW;
   localparam int EdgeW     = 18;

   localparam logic signed [AccW-1:0] MaxQ = AccW'(32767);
   localparam logic signed [AccW-1:0] MinQ = -AccW'(32768);
   localparam logic signed [AccW-1:0] Half = AccW'(2048);

   typedef enum logic [6:0] {
      StIdle    = 7'b0000001,
      StInit    = 7'b0000010,
      StEdges   = 7'b0000100,
      StDrain   = 7'b0001000,
      StNodeEnd = 7'b0010000,
      StHistWr  = 7'b0100000,
      StResult  = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [EdgeAw-1:0]       init_addr_ff, init_addr_in;
   logic [NodeW-1:0]        node_ff, node_in;
   logic [NodeW-1:0]        src_ff, src_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic [NodeW-1:0]        s1_src_ff, s1_src_in;
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_gain_ff, s2_gain_in;
   logic                    s2_hist_ff, s2_hist_in;
   logic signed [31:0]      prod_ff, prod_in;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic signed [15:0]      cur_ff [NODE_COUNT];
   logic signed [15:0]      cur_in [NODE_COUNT];
   logic                    sat_ff, sat_in;
   logic [SlotW-1:0]        ptr_ff, ptr_in;
   logic [CntW-1:0]         fill_ff, fill_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sfg_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   sfg_pkg::rsp_type        res_ff, res_in;

   logic                    edge_wr_en;
   logic [EdgeAw-1:0]       edge_wr_addr;
   logic [EdgeW-1:0]        edge_wr_data;
   logic [EdgeW-1:0]        edge_rd_data;
   logic                    hist_wr_en;
   logic [HistAw-1:0]       hist_rd_addr;
   logic [15:0]             hist_rd_data;

   logic [IdxW-1:0]         wr_src_wide, wr_snk_wide;
   logic [1:0]              s1_kind;
   logic signed [15:0]      s1_value;
   logic [NodeW-1:0]        cur_idx;
   logic signed [15:0]      cur_rd;
   logic [16:0]             slot_sum;
   logic [SlotW-1:0]        slot;
   logic signed [AccW-1:0]  term;
   logic signed [AccW-1:0]  rnd;
   logic signed [15:0]      node_val;
   logic                    node_clip;

   sfg_ram #(.WIDTH(EdgeW), .DEPTH(EdgeDepth)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_addr ({src_ff, node_ff}),
      .rd_data (edge_rd_data)
   );

   sfg_ram #(.WIDTH(16), .DEPTH(HistDepth)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr ({ptr_ff, src_ff}),
      .wr_data (cur_rd),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   assign wr_src_wide = IdxW'(job_data.req.source_node);
   assign wr_snk_wide = IdxW'(job_data.req.sink_node);

   // Stage one: edge entry is out of the table.
   assign s1_kind  = edge_rd_data[EdgeW-1:16];
   assign s1_value = $signed(edge_rd_data[15:0]);
   assign cur_idx  = (state_ff == StHistWr) ? src_ff : s1_src_ff;
   assign cur_rd   = cur_ff[cur_idx];

   always_comb begin
      slot_sum = 17'(ptr_ff) + 17'(DELAY_LIMIT) - 17'($unsigned(s1_value));
      if (slot_sum >= 17'(DELAY_LIMIT)) begin
         slot_sum = slot_sum - 17'(DELAY_LIMIT);
      end
      slot = slot_sum[SlotW-1:0];
   end
   assign hist_rd_addr = {slot, s1_src_ff};

   // Stage two: the term to add to the node sum.
   always_comb begin
      if (s2_gain_ff) begin
         term = AccW'(prod_ff);
      end else if (s2_hist_ff) begin
         term = AccW'($signed({hist_rd_data, 12'b0}));
      end else begin
         term = '0;
      end
   end

   // Round half up and saturate the finished node sum.
   always_comb begin
      rnd       = (acc_ff + Half) >>> sfg_pkg::GainFrac;
      node_clip = 1'b0;
      if (rnd > MaxQ) begin
         node_val  = 16'sd32767;
         node_clip = 1'b1;
      end else if (rnd < MinQ) begin
         node_val  = -16'sd32768;
         node_clip = 1'b1;
      end else begin
         node_val = rnd[15:0];
      end
   end

   assign back_status.init_done = (state_ff != StInit);
   assign back_status.job_ready = (state_ff == StIdle);

   always_comb begin
      state_in     = state_ff;
      init_addr_in = init_addr_ff;
      node_in      = node_ff;
      src_in       = src_ff;
      s1_valid_in  = 1'b0;
      s1_src_in    = src_ff;
      s2_valid_in  = s1_valid_ff;
      s2_gain_in   = s1_valid_ff && (s1_kind == sfg_pkg::KindGain) && (s1_src_ff < node_ff);
      s2_hist_in   = s1_valid_ff && (s1_kind == sfg_pkg::KindDelay) &&
                     (17'($unsigned(s1_value)) <= 17'(fill_ff));
      prod_in      = s1_value * cur_rd;
      acc_in       = s2_valid_ff ? (acc_ff + term) : acc_ff;
      cur_in       = cur_ff;
      sat_in       = sat_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      edge_wr_en   = 1'b0;
      edge_wr_addr = {wr_src_wide[NodeW-1:0], wr_snk_wide[NodeW-1:0]};
      edge_wr_data = {job_data.req.edge_kind,
                      (job_data.req.edge_kind == sfg_pkg::KindNone) ?
                      16'd0 : job_data.req.edge_value};
      hist_wr_en   = 1'b0;

      case (state_ff)
         StInit: begin
            edge_wr_en   = 1'b1;
            edge_wr_addr = init_addr_ff;
            edge_wr_data = '0;
            init_addr_in = init_addr_ff + 1'b1;
            if (init_addr_ff == EdgeAw'(EdgeDepth - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (job_valid) begin
               res_in   = '0;
               state_in = StResult;
               case (job_data.op)
                  sfg_pkg::OpWrite: begin
                     edge_wr_en = 1'b1;
                  end
                  sfg_pkg::OpClear: begin
                     ptr_in  = '0;
                     fill_in = '0;
                  end
                  sfg_pkg::OpSample: begin
                     acc_in   = AccW'($signed({job_data.req.sample_in, 12'b0}));
                     node_in  = '0;
                     src_in   = '0;
                     sat_in   = 1'b0;
                     state_in = StEdges;
                  end
                  default: begin
                     res_in.write_error = job_data.write_error;
                  end
               endcase
            end
         end
         StEdges: begin
            s1_valid_in = 1'b1;
            if (src_ff == NodeW'(NODE_COUNT - 1)) begin
               state_in = StDrain;
            end else begin
               src_in = src_ff + 1'b1;
            end
         end
         StDrain: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = StNodeEnd;
            end
         end
         StNodeEnd: begin
            cur_in[node_ff] = node_val;
            sat_in          = sat_ff || node_clip;
            src_in          = '0;
            if (node_ff == NodeW'(NODE_COUNT - 1)) begin
               state_in = StHistWr;
            end else begin
               node_in  = node_ff + 1'b1;
               acc_in   = '0;
               state_in = StEdges;
            end
         end
         StHistWr: begin
            hist_wr_en = 1'b1;
            if (src_ff == NodeW'(NODE_COUNT - 1)) begin
               ptr_in  = (ptr_ff == SlotW'(DELAY_LIMIT - 1)) ? '0 : ptr_ff + 1'b1;
               fill_in = (fill_ff == CntW'(DELAY_LIMIT)) ? fill_ff : fill_ff + 1'b1;
               res_in.sample_out  = cur_ff[NodeW'(NODE_COUNT - 1)];
               res_in.write_error = 1'b0;
               res_in.saturated   = sat_ff;
               state_in = StResult;
            end else begin
               src_in = src_ff + 1'b1;
            end
         end
         StResult: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StInit;
         init_addr_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      src_ff      <= src_in;
      s1_src_ff   <= s1_src_in;
      s2_gain_ff  <= s2_gain_in;
      s2_hist_ff  <= s2_hist_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      cur_ff      <= cur_in;
      sat_ff      <= sat_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
                    s2_valid_ff |-> (state_ff == StEdges || state_ff == StDrain))
      else $error("accumulate stage busy outside edge walk");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == StNodeEnd) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("node finished with terms still in flight");
   assert property (@(posedge clock) disable iff (reset) fill_ff <= CntW'(DELAY_LIMIT))
      else $error("history fill count beyond delay limit");

endmodule

// ===== verif/signal_flow_graph_filter_checker.sv =====
// Response checker for the signal flow graph filter: predicts each response and compares it.
module signal_flow_graph_filter_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  sfg_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  sfg_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sfg_pkg::*;

   localparam int Nodes = DefNodeCount;
   localparam int Depth = DefDelayLimit;

   logic [1:0]         kind_tab [Nodes][Nodes];
   logic signed [15:0] value_tab [Nodes][Nodes];
   logic signed [15:0] history [Depth][Nodes];
   int                 hist_ptr;
   rsp_type            expected_rsp [$];

   task automatic clear_history();
      for (int r = 0; r < Depth; r++)
         for (int n = 0; n < Nodes; n++)
            history[r][n] = '0;
      hist_ptr = 0;
   endtask

   function automatic longint floor_div(longint a);
      if (a >= 0) return a / 4096;
      return -((-a + 4095) / 4096);
   endfunction

   task automatic filter_step(input req_type rq, output rsp_type rs);
      logic signed [15:0] cur [Nodes];
      longint             acc;
      longint             r;
      int                 d;
      int                 slot;
      rs = '0;
      case (rq.command)
         CmdWrite: begin
            if (rq.edge_kind == 2'd3)
               rs.write_error = 1'b1;
            else if (rq.edge_kind == KindDelay &&
                     (rq.edge_value < 1 || rq.edge_value > Depth))
               rs.write_error = 1'b1;
            else begin
               kind_tab[rq.source_node][rq.sink_node] = rq.edge_kind;
               value_tab[rq.source_node][rq.sink_node] =
                  (rq.edge_kind == KindNone) ? 16'sd0 : rq.edge_value;
            end
         end
         CmdSample: begin
            for (int j = 0; j < Nodes; j++) begin
               acc = (j == 0) ? longint'(rq.sample_in) * 4096 : 0;
               for (int s = 0; s < Nodes; s++) begin
                  if (kind_tab[s][j] == KindGain && s < j)
                     acc += longint'(value_tab[s][j]) * longint'(cur[s]);
                  else if (kind_tab[s][j] == KindDelay) begin
                     d = value_tab[s][j];
                     slot = (hist_ptr + Depth - d) % Depth;
                     acc += longint'(history[slot][s]) * 4096;
                  end
               end
               r = floor_div(acc + 2048);
               if (r > 32767) begin
                  r = 32767;
                  rs.saturated = 1'b1;
               end else if (r < -32768) begin
                  r = -32768;
                  rs.saturated = 1'b1;
               end
               cur[j] = r[15:0];
            end
            for (int j = 0; j < Nodes; j++) history[hist_ptr][j] = cur[j];
            hist_ptr = (hist_ptr + 1) % Depth;
            rs.sample_out = cur[Nodes-1];
         end
         CmdClear: clear_history();
         default: ;
      endcase
   endtask

   initial begin
      for (int s = 0; s < Nodes; s++)
         for (int j = 0; j < Nodes; j++) begin
            kind_tab[s][j] = KindNone;
            value_tab[s][j] = '0;
         end
      clear_history();
      fail_count = 0;
   end

   assign pending_count = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type pred;
      rsp_type want;
      if (!reset && req_valid && req_ready) begin
         filter_step(req_data, pred);
         expected_rsp = {expected_rsp, pred};
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response transaction with no expectation waiting");
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.sample_out !== want.sample_out) begin
               $error("sample_out expected %0d actual %0d", want.sample_out,
                      rsp_data.sample_out);
               fail_count++;
            end
            if (rsp_data.write_error !== want.write_error) begin
               $error("write_error expected %0b actual %0b", want.write_error,
                      rsp_data.write_error);
               fail_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated expected %0b actual %0b", want.saturated,
                      rsp_data.saturated);
               fail_count++;
            end
         end
      end
   end

endmodule

// ===== verif/signal_flow_graph_filter_tb.sv =====
// Testbench top for the signal flow graph filter: stimulus, idling and verdict.
module signal_flow_graph_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfg_pkg::*;

   localparam int ReqBits = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   // Idle percentages of the sender and the receiver, changed per phase.
   int      send_idle_pct;
   int      recv_idle_pct;

   signal_flow_graph_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   signal_flow_graph_filter_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The receiver drops ready at random; a fresh decision is made every cycle.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // A request with every field random.
   function automatic req_type random_request();
      return req_type'(ReqBits'({$urandom(), $urandom()}));
   endfunction

   // Presents one transaction and holds it until the block accepts it. An idle
   // gap before valid rises is drawn from the sender's idle percentage.
   task automatic send_transaction(input req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_edge(input int src, input int snk, input logic [1:0] kind,
                             input logic signed [15:0] val);
      req_type rq;
      rq = '0;
      rq.command     = CmdWrite;
      rq.source_node = src[2:0];
      rq.sink_node   = snk[2:0];
      rq.edge_kind   = kind;
      rq.edge_value  = val;
      rq.sample_in   = 16'($urandom());
      send_transaction(rq);
   endtask

   task automatic send_sample(input logic signed [15:0] x);
      req_type rq;
      rq = random_request();
      rq.command   = CmdSample;
      rq.sample_in = x;
      send_transaction(rq);
   endtask

   task automatic send_command(input logic [1:0] cmd);
      req_type rq;
      rq = random_request();
      rq.command = cmd;
      send_transaction(rq);
   endtask

   // Random delay lengths are mostly legal; the rest probe the range check.
   function automatic logic signed [15:0] random_delay();
      if ($urandom_range(9) < 8) return 16'($urandom_range(16, 1));
      case ($urandom_range(3))
         0: return 16'sd0;
         1: return 16'sd17;
         2: return 16'sh8000;
         default: return 16'($urandom());
      endcase
   endfunction

   // Gains are kept small most of the time so that sums stay in range, with
   // the occasional full-scale gain to drive saturation.
   function automatic logic signed [15:0] random_gain();
      if ($urandom_range(9) < 7) return 16'($signed(13'($urandom())) >>> 1);
      return 16'($urandom());
   endfunction

   // One random transaction: samples and well-formed graph edits are
   // the bulk, with clears, unknown commands and raw noise mixed in.
   task automatic random_transaction();
      int       pick;
      int       src;
      int       snk;
      req_type  rq;
      pick = $urandom_range(99);
      src  = $urandom_range(7);
      snk  = $urandom_range(7);
      if (pick < 55)
         send_sample(16'($urandom()));
      else if (pick < 72)
         write_edge(src < snk ? src : snk, src < snk ? snk : src, KindGain, random_gain());
      else if (pick < 84)
         write_edge(src, snk, KindDelay, random_delay());
      else if (pick < 89)
         write_edge(src, snk, KindNone, 16'($urandom()));
      else if (pick < 93)
         send_command(CmdClear);
      else begin
         rq = random_request();
         send_transaction(rq);
      end
   endtask

   initial begin
      send_idle_pct = 18;
      recv_idle_pct = 62;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: a feed-forward chain, a delay path, every edge kind,
      // rejected writes and saturation in both directions.
      write_edge(0, 7, KindGain, 16'sh1000);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      write_edge(0, 7, KindGain, 16'sh7fff);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      write_edge(0, 7, KindGain, 16'sh8000);
      send_sample(16'sh4000);
      write_edge(7, 3, KindGain, 16'sh1000);
      write_edge(0, 0, KindGain, 16'sh1000);
      write_edge(0, 7, KindDelay, 16'sd1);
      write_edge(7, 7, KindDelay, 16'sd16);
      write_edge(0, 6, KindDelay, 16'sd0);
      write_edge(0, 6, KindDelay, 16'sd17);
      write_edge(1, 2, 2'd3, 16'sh0123);
      send_sample(16'sh1234);
      send_sample(16'shedcb);
      send_sample(16'sh0001);
      send_command(CmdClear);
      send_sample(16'sh0000);
      send_command(2'd3);
      write_edge(7, 7, KindNone, 16'sh7fff);
      write_edge(0, 7, KindNone, 16'sh8000);
      send_sample(16'sh2000);

      // Random part in three idling phases, the last with no idling at all.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 62 : 0;
         recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 18 : 0;
         for (int i = 0; i < 230; i++) random_transaction();
      end
      req_valid <= 1'b0;

      wait (pending_count == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // About 720 transactions plus stalls fit
   // well inside this bound.
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sfg_pkg.sv
rtl/sfg_ram.sv
rtl/sfg_front.sv
rtl/sfg_back.sv
rtl/signal_flow_graph_filter.sv
verif/signal_flow_graph_filter_checker.sv
verif/signal_flow_graph_filter_tb.sv
